// ===== rtl/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants for the perspective point projection
// Widths of the fixed-point datapath, register indexes, reset values and the
// tag word that travels with each point through the quotient pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppp_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int COORD_W = 32;               // coordinates and outputs
  localparam int DIFF_W  = COORD_W + 1;      // exact point - camera offset
  localparam int ENTRY_W = 16;               // Q2.14 basis entry
  localparam int PROD_W  = ENTRY_W + DIFF_W; // one basis product
  localparam int ROT_W   = PROD_W + 1;       // sum of three products, |r| < 2^49
  localparam int QUO_W   = COORD_W;          // quotient bits developed
  localparam int LANES   = 2;                // horizontal and vertical
  localparam int MAG_W_DEF = ROT_W + COORD_W + 1;

  // point enters, offset, products, rotation, focal products, numerator,
  // sign fold, divider entry, quotient steps, output register
  localparam int PIPE_LATENCY = 6 + 1 + QUO_W + 1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 3 * ENTRY_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_BASIS_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASIS_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASIS_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAM_X   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAM_Y   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAM_Z   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOCAL   = 3'd6;

  localparam logic [CFG_DATA_W-1:0] BASIS_X_RST = 48'h0000_0000_4000;
  localparam logic [CFG_DATA_W-1:0] BASIS_Y_RST = 48'h0000_4000_0000;
  localparam logic [CFG_DATA_W-1:0] BASIS_Z_RST = 48'h4000_0000_0000;
  localparam logic [COORD_W-1:0]    FOCAL_RST   = 32'h0001_0000;

  localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic             valid;
    logic             zero;   // depth is exactly zero
    logic [LANES-1:0] neg;    // quotient is negative (or sign of r when zero)
    logic [LANES-1:0] ovf;    // magnitude of quotient reaches 2^32
  } ppp_tag_t;

endpackage

// ===== rtl/ppp_div_pipe.sv =====
// ----------------------------------------------------------------------------
// ppp_div_pipe: two-lane restoring divider, one quotient bit per stage
// Both lanes share one divisor. The entry stage flags quotients of 2^32 and
// above; each following stage develops one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppp_div_pipe
  import ppp_pkg::*;
#(
  parameter int MAG_W = MAG_W_DEF,
  parameter int DEN_W = ROT_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ppp_tag_t                     in_tag,
  input  logic [LANES-1:0][MAG_W-1:0]  in_mag,
  input  logic [DEN_W-1:0]             in_den,
  output ppp_tag_t                     out_tag,
  output logic [LANES-1:0][QUO_W-1:0]  out_quo,
  output logic [LANES-1:0]             out_rem_nz
);

  localparam int HI_W  = MAG_W - QUO_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  ppp_tag_t         tag [0:QUO_W];
  logic [DEN_W-1:0] den [0:QUO_W-1];
  logic [DEN_W-1:0] rem [0:QUO_W][LANES];
  logic [QUO_W-1:0] lq  [0:QUO_W][LANES];   // dividend bits out, quotient bits in

  ppp_tag_t         tag_next;
  logic [LANES-1:0] ovf_next;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ovf_next[l] = CMP_W'(in_mag[l][MAG_W-1:QUO_W]) >= CMP_W'(in_den);
    end
    tag_next     = in_tag;
    tag_next.ovf = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0] <= '0;
    end else begin
      tag[0] <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    den[0] <= in_den;
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] <= DEN_W'(in_mag[l][MAG_W-1:QUO_W]);
      lq[0][l]  <= in_mag[l][QUO_W-1:0];
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        tag[k] <= '0;
      end else begin
        tag[k] <= tag[k-1];
      end
    end

    // the last step has no later stage that needs the divisor
    if (k < QUO_W) begin : g_den
      always_ff @(posedge clk) begin
        den[k] <= den[k-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] trial;
      logic           ge;

      assign trial = {rem[k-1][l], lq[k-1][l][QUO_W-1]};
      assign ge    = trial >= {1'b0, den[k-1]};

      always_ff @(posedge clk) begin
        if (ge) begin
          rem[k][l] <= DEN_W'(trial - {1'b0, den[k-1]});
        end else begin
          rem[k][l] <= DEN_W'(trial);
        end
        lq[k][l] <= {lq[k-1][l][QUO_W-2:0], ge};
      end
    end
  end

  assign out_tag = tag[QUO_W];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l]    = lq[QUO_W][l];
      out_rem_nz[l] = |rem[QUO_W][l];
    end
  end

endmodule

// ===== rtl/perspective_point_projection.sv =====
// ----------------------------------------------------------------------------
// perspective_point_projection: world point to normalized screen position
// Takes one world point per cycle whenever start is high; busy stays low, so
// every start is taken. Each point gives one result, marked by done, in order;
// the receiver cannot stall it and must take each word in the cycle it appears.
// The quotient pipeline develops one of the 32 quotient bits per stage.
// Write the camera registers only when no point is in flight. Outputs are
// floor((r * f / depth + 1) / 2) in Q16.16, saturated; a zero depth raises
// zero_depth and saturates each output by the sign of its rotated value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_point_projection
  import ppp_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  output logic                      done,
  output logic signed [COORD_W-1:0] screen_u,
  output logic signed [COORD_W-1:0] screen_v,
  output logic                      zero_depth,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int SHIFT_W = (COORD_FRAC_BITS > COORD_W) ? COORD_FRAC_BITS : COORD_W;
  localparam int NUM_W   = ROT_W + SHIFT_W + 1;
  localparam int RHI_W   = ROT_W - COORD_W;
  localparam int PHI_W   = RHI_W + COORD_W + 1;

  // configuration registers
  logic [CFG_DATA_W-1:0]     basis_x, basis_y, basis_z;
  logic signed [COORD_W-1:0] cam_x, cam_y, cam_z;
  logic [COORD_W-1:0]        focal;
  logic [CFG_DATA_W-1:0]     rows [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_x <= BASIS_X_RST;
      basis_y <= BASIS_Y_RST;
      basis_z <= BASIS_Z_RST;
      cam_x   <= '0;
      cam_y   <= '0;
      cam_z   <= '0;
      focal   <= FOCAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASIS_X: basis_x <= cfg_data;
        CFG_BASIS_Y: basis_y <= cfg_data;
        CFG_BASIS_Z: basis_z <= cfg_data;
        CFG_CAM_X:   cam_x   <= $signed(cfg_data[COORD_W-1:0]);
        CFG_CAM_Y:   cam_y   <= $signed(cfg_data[COORD_W-1:0]);
        CFG_CAM_Z:   cam_z   <= $signed(cfg_data[COORD_W-1:0]);
        CFG_FOCAL:   focal   <= cfg_data[COORD_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  assign rows[0] = basis_x;
  assign rows[1] = basis_y;
  assign rows[2] = basis_z;

  // stage 1: offset from camera
  logic                     v1;
  logic signed [DIFF_W-1:0] d1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    d1[0] <= DIFF_W'(point_x) - DIFF_W'(cam_x);
    d1[1] <= DIFF_W'(point_y) - DIFF_W'(cam_y);
    d1[2] <= DIFF_W'(point_z) - DIFF_W'(cam_z);
  end

  // stage 2: nine basis products
  logic                     v2;
  logic signed [PROD_W-1:0] prod2 [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        prod2[i][j] <= PROD_W'($signed(rows[i][ENTRY_W*j +: ENTRY_W])) *
                       PROD_W'(d1[j]);
      end
    end
  end

  // stage 3: rotated offset
  logic                    v3;
  logic signed [ROT_W-1:0] r3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sum
    always_ff @(posedge clk) begin
      r3[i] <= ROT_W'(prod2[i][0]) + ROT_W'(prod2[i][1]) + ROT_W'(prod2[i][2]);
    end
  end

  // stage 4: focal products, split at bit 32 of the rotated value
  logic                     v4;
  logic signed [PHI_W-1:0]  ph4 [LANES];
  logic [2*COORD_W-1:0]     pl4 [LANES];
  logic signed [ROT_W-1:0]  ry4;
  logic [LANES-1:0]         sgn4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_focal
    localparam int A = 2 * l;   // horizontal row, then vertical row
    always_ff @(posedge clk) begin
      ph4[l]  <= PHI_W'($signed(r3[A][ROT_W-1:COORD_W])) * PHI_W'($signed({1'b0, focal}));
      pl4[l]  <= (2*COORD_W)'(r3[A][COORD_W-1:0]) * (2*COORD_W)'(focal);
      sgn4[l] <= r3[A][ROT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    ry4 <= r3[1];
  end

  // stage 5: numerator r * f + depth * one
  logic                    v5;
  logic signed [NUM_W-1:0] num5 [LANES];
  logic signed [ROT_W-1:0] ry5;
  logic                    zero5;
  logic                    ryneg5;
  logic [LANES-1:0]        sgn5;
  logic signed [NUM_W-1:0] num_hi [LANES];
  logic signed [NUM_W-1:0] num_lo [LANES];
  logic signed [NUM_W-1:0] num_one;

  assign num_one = NUM_W'(ry4) <<< COORD_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_num
    assign num_hi[l] = NUM_W'(ph4[l]) <<< COORD_W;
    assign num_lo[l] = $signed(NUM_W'(pl4[l]));
    always_ff @(posedge clk) begin
      num5[l] <= num_hi[l] + num_lo[l] + num_one;
    end
  end

  always_ff @(posedge clk) begin
    ry5    <= ry4;
    zero5  <= (ry4 == '0);
    ryneg5 <= ry4[ROT_W-1];
    sgn5   <= sgn4;
  end

  // stage 6: fold signs so the divisor is positive, take magnitudes
  ppp_tag_t                   tag6;
  ppp_tag_t                   tag6_next;
  logic [LANES-1:0][NUM_W-1:0] mag6;
  logic [ROT_W-1:0]           den6;
  logic [ROT_W-1:0]           abs_ry;

  assign abs_ry = ryneg5 ? ROT_W'(-ry5) : ROT_W'(ry5);

  always_comb begin
    tag6_next       = '0;
    tag6_next.valid = v5;
    tag6_next.zero  = zero5;
    for (int l = 0; l < LANES; l++) begin
      tag6_next.neg[l] = zero5 ? sgn5[l] : (num5[l][NUM_W-1] ^ ryneg5);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag6 <= '0;
    end else begin
      tag6 <= tag6_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      mag6[l] <= num5[l][NUM_W-1] ? NUM_W'(-num5[l]) : NUM_W'(num5[l]);
    end
    den6 <= {abs_ry[ROT_W-2:0], 1'b0};
  end

  // quotient pipeline
  ppp_tag_t                    div_tag;
  logic [LANES-1:0][QUO_W-1:0] div_quo;
  logic [LANES-1:0]            div_rem_nz;

  ppp_div_pipe #(
    .MAG_W (NUM_W),
    .DEN_W (ROT_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_tag     (tag6),
    .in_mag     (mag6),
    .in_den     (den6),
    .out_tag    (div_tag),
    .out_quo    (div_quo),
    .out_rem_nz (div_rem_nz)
  );

  // floor, saturate, register the result word
  logic [COORD_W-1:0] res_next [LANES];

  always_comb begin
    logic [QUO_W:0] up;
    for (int l = 0; l < LANES; l++) begin
      up = {1'b0, div_quo[l]} + {{QUO_W{1'b0}}, div_rem_nz[l]};
      if (div_tag.zero) begin
        res_next[l] = div_tag.neg[l] ? SAT_MIN : SAT_MAX;
      end else if (!div_tag.neg[l]) begin
        res_next[l] = (div_tag.ovf[l] || div_quo[l][QUO_W-1]) ? SAT_MAX : div_quo[l];
      end else if (div_tag.ovf[l] || up > {1'b0, SAT_MIN}) begin
        res_next[l] = SAT_MIN;
      end else begin
        res_next[l] = COORD_W'(-up);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    screen_u   <= $signed(res_next[0]);
    screen_v   <= $signed(res_next[1]);
    zero_depth <= div_tag.zero;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("accepted point gave no result word at the fixed latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result word without an accepted point");

  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    (done && zero_depth) |->
      ((screen_u == SAT_MAX || screen_u == SAT_MIN) &&
       (screen_v == SAT_MAX || screen_v == SAT_MIN)))
    else $error("zero depth result not saturated");

endmodule

// ===== tb/sv/tb_perspective_point_projection.sv =====
// ----------------------------------------------------------------------------
// tb_perspective_point_projection: self-checking bench for the point projector
// Streams world points through the block under a range of camera settings and
// compares every screen word against a bit-exact projection computed here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_perspective_point_projection;
  import ppp_pkg::*;

  localparam int CLK_HALF = 2;
  localparam int FRAC_BITS = COORD_FRAC_BITS_DEF;
  localparam int PHASES = 10;
  localparam int POINTS_PER_PHASE = 125;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic signed [127:0] QUO_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] QUO_MIN = -128'sh8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic                      zd;
  } screen_pos_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic                      done;
  logic signed [COORD_W-1:0] screen_u;
  logic signed [COORD_W-1:0] screen_v;
  logic                      zero_depth;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // shadow copy of the camera registers
  logic [CFG_DATA_W-1:0]     basis_reg [3];
  logic signed [COORD_W-1:0] cam_reg [3];
  logic [COORD_W-1:0]        focal_reg;

  screen_pos_t expected_screen [$];
  screen_pos_t head_pos;

  int idle_pct = 31;
  int fail_count = 0;
  int points_sent = 0;
  int results_seen = 0;
  int zero_depth_count = 0;
  int saturated_count = 0;
  int reg_writes = 0;

  always #(CLK_HALF) clk = ~clk;

  perspective_point_projection uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .done       (done),
    .screen_u   (screen_u),
    .screen_v   (screen_v),
    .zero_depth (zero_depth),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // floor((ra * f + ry * 2^F) / (2 * ry)), saturated to 32 bits
  function automatic logic signed [COORD_W-1:0] screen_coord(input longint ra,
                                                             input longint ry);
    logic signed [127:0] num, den, quo, rem, f_w, ra_w, ry_w;
    ra_w = 128'(ra);
    ry_w = 128'(ry);
    f_w  = 128'(focal_reg);
    num  = ra_w * f_w + (ry_w <<< FRAC_BITS);
    den  = ry_w <<< 1;
    if (ry_w < 0) begin
      num = -num;
      den = -den;
    end
    quo = num / den;
    rem = num % den;
    // division truncates; step down for negative inexact quotients
    if (rem != 0 && num < 0) quo = quo - 1;
    if (quo > QUO_MAX) return SAT_MAX;
    if (quo < QUO_MIN) return SAT_MIN;
    return quo[COORD_W-1:0];
  endfunction

  function automatic screen_pos_t project_point(input logic signed [COORD_W-1:0] px,
                                                input logic signed [COORD_W-1:0] py,
                                                input logic signed [COORD_W-1:0] pz);
    longint ofs [3];
    longint rot [3];
    logic signed [ENTRY_W-1:0] coef;
    screen_pos_t res;
    ofs[0] = longint'(px) - longint'(cam_reg[0]);
    ofs[1] = longint'(py) - longint'(cam_reg[1]);
    ofs[2] = longint'(pz) - longint'(cam_reg[2]);
    for (int i = 0; i < 3; i++) begin
      rot[i] = 0;
      for (int j = 0; j < 3; j++) begin
        coef = basis_reg[i][ENTRY_W*j +: ENTRY_W];
        rot[i] += longint'(coef) * ofs[j];
      end
    end
    if (rot[1] == 0) begin
      res.u  = (rot[0] < 0) ? SAT_MIN : SAT_MAX;
      res.v  = (rot[2] < 0) ? SAT_MIN : SAT_MAX;
      res.zd = 1'b1;
    end else begin
      res.u  = screen_coord(rot[0], rot[1]);
      res.v  = screen_coord(rot[2], rot[1]);
      res.zd = 1'b0;
    end
    return res;
  endfunction

  // random upper bits on 32-bit registers; the block must drop them
  function automatic logic [CFG_DATA_W-1:0] pad32(input logic [COORD_W-1:0] val);
    return {16'($urandom()), val};
  endfunction

  task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic [COORD_W-1:0] pz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    do @(posedge clk); while (busy);
    expected_screen.push_back(project_point(px, py, pz));
    points_sent++;
  endtask

  // hold off new points until every pending word has come back
  task automatic drain_points();
    start <= 1'b0;
    do @(posedge clk); while (expected_screen.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASIS_X: basis_reg[0] = data;
      CFG_BASIS_Y: basis_reg[1] = data;
      CFG_BASIS_Z: basis_reg[2] = data;
      CFG_CAM_X:   cam_reg[0] = data[COORD_W-1:0];
      CFG_CAM_Y:   cam_reg[1] = data[COORD_W-1:0];
      CFG_CAM_Z:   cam_reg[2] = data[COORD_W-1:0];
      CFG_FOCAL:   focal_reg = data[COORD_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic end_reg_writes();
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_point(32'd0, 32'd0, 32'd0);
    send_point(-32'sd1, 32'd0, -32'sd1);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'd1, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // behind the camera
    send_point(32'd1, -32'sh0001_0000, 32'd3);
    // inexact quotients, both signs
    send_point(-32'sd1, 32'd3, 32'd0);
    send_point(-32'sd5, 32'd3, 32'd0);
  endtask

  task automatic test_register_extremes();
    drain_points();
    write_reg(CFG_BASIS_X, 48'h8000_8000_8000);
    write_reg(CFG_BASIS_Y, 48'h8000_8000_8000);
    write_reg(CFG_BASIS_Z, 48'h8000_8000_8000);
    write_reg(CFG_CAM_X, pad32(32'h7FFF_FFFF));
    write_reg(CFG_CAM_Y, pad32(32'h8000_0000));
    write_reg(CFG_CAM_Z, pad32(32'd0));
    write_reg(CFG_FOCAL, pad32(32'hFFFF_FFFF));
    write_reg(CFG_UNUSED, 48'({$urandom(), $urandom()}));
    end_reg_writes();
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'd0, 32'd0, 32'd0);

    drain_points();
    write_reg(CFG_BASIS_X, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_BASIS_Y, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_BASIS_Z, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_CAM_X, pad32(32'h8000_0000));
    write_reg(CFG_CAM_Y, pad32(32'h7FFF_FFFF));
    write_reg(CFG_CAM_Z, pad32(32'h7FFF_FFFF));
    write_reg(CFG_FOCAL, pad32(32'd0));
    end_reg_writes();
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'd0, 32'h1234_5678, 32'd0);

    // a null basis gives zero depth everywhere
    drain_points();
    write_reg(CFG_BASIS_X, '0);
    write_reg(CFG_BASIS_Y, '0);
    write_reg(CFG_BASIS_Z, '0);
    end_reg_writes();
    send_point(32'd0, 32'd0, 32'd0);
    send_point($urandom(), $urandom(), $urandom());
  endtask

  task automatic test_random_projection();
    int axis_col [3];
    int kind;
    int sel;
    logic [COORD_W-1:0] pt [3];
    logic [COORD_W-1:0] val;
    logic [CFG_DATA_W-1:0] row;
    logic signed [ENTRY_W-1:0] mag;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_points();
      // pure axis basis, random rows, or axis basis with small cross terms
      kind = phase % 3;
      axis_col[0] = $urandom_range(2);
      axis_col[1] = (axis_col[0] + $urandom_range(1, 2)) % 3;
      axis_col[2] = 3 - axis_col[0] - axis_col[1];
      for (int r = 0; r < 3; r++) begin
        if (kind == 1) begin
          row = 48'({$urandom(), $urandom()});
        end else begin
          row = (kind == 2) ? 48'({$urandom(), $urandom()}) & 48'h00FF_00FF_00FF : '0;
          mag = 16'($urandom_range(16'h2000, 16'h7FFF));
          if ($urandom_range(1)) mag = -mag;
          row[ENTRY_W*axis_col[r] +: ENTRY_W] = mag;
        end
        write_reg(CFG_INDEX_W'(CFG_BASIS_X + r), row);
      end
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(3) == 0) val = $urandom();
        else val = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
        write_reg(CFG_INDEX_W'(CFG_CAM_X + r), pad32(val));
      end
      if ($urandom_range(3) == 0) val = $urandom();
      else val = $urandom_range(32'h0000_4000, 32'h0004_0000);
      write_reg(CFG_FOCAL, pad32(val));
      end_reg_writes();

      idle_pct = (phase == 4) ? 0 : 31;
      repeat (POINTS_PER_PHASE) begin
        sel = $urandom_range(99);
        for (int k = 0; k < 3; k++) begin
          if (sel < 15) pt[k] = $urandom();
          else if (sel < 25) pt[k] = cam_reg[k] + ($urandom_range(0, 511) - 256);
          else pt[k] = cam_reg[k] + ($urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000);
        end
        // put the point on the image plane through the camera
        if (sel >= 85 && kind == 0) pt[axis_col[1]] = cam_reg[axis_col[1]];
        send_point(pt[0], pt[1], pt[2]);
      end
    end
    idle_pct = 31;
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (zero_depth === 1'b1) zero_depth_count++;
      if (screen_u == SAT_MAX || screen_u == SAT_MIN) saturated_count++;
      if (screen_v == SAT_MAX || screen_v == SAT_MIN) saturated_count++;
      if (expected_screen.size() == 0) begin
        $error("screen word with no point pending: u %0d v %0d zero_depth %0b",
               screen_u, screen_v, zero_depth);
        fail_count++;
      end else begin
        head_pos = expected_screen.pop_front();
        if (screen_u !== head_pos.u) begin
          $error("screen_u mismatch: expected %0d, got %0d", head_pos.u, screen_u);
          fail_count++;
        end
        if (screen_v !== head_pos.v) begin
          $error("screen_v mismatch: expected %0d, got %0d", head_pos.v, screen_v);
          fail_count++;
        end
        if (zero_depth !== head_pos.zd) begin
          $error("zero_depth mismatch: expected %0b, got %0b", head_pos.zd, zero_depth);
          fail_count++;
        end
      end
    end
  end

  initial begin
    basis_reg[0] = BASIS_X_RST;
    basis_reg[1] = BASIS_Y_RST;
    basis_reg[2] = BASIS_Z_RST;
    cam_reg[0]   = '0;
    cam_reg[1]   = '0;
    cam_reg[2]   = '0;
    focal_reg    = FOCAL_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_random_projection();
    drain_points();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    $display("Projected %0d points through %0d register writes; %0d words checked.",
             points_sent, reg_writes, results_seen);
    $display("Seen %0d zero-depth words and %0d saturated coordinates.",
             zero_depth_count, saturated_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ppp_pkg.sv
rtl/ppp_div_pipe.sv
rtl/perspective_point_projection.sv
tb/sv/tb_perspective_point_projection.sv
